### hw/rtl/bbe_pkg.sv
package bbe_pkg;

	localparam int MAX_COLS_DEF     = 2048;
	localparam int CHANNEL_BITS_DEF = 8;

	localparam logic [15:0] ROWS_RESET = 16'd480;
	localparam logic [11:0] COLS_RESET = 12'd640;

	typedef enum logic {
		REG_FRAME_ROWS = 1'b0,
		REG_FRAME_COLS = 1'b1
	} reg_index_t;

	// neighbor offsets, clockwise from the pixel above
	localparam logic signed [1:0] NB_DR [8] = '{-2'sd1, -2'sd1, 2'sd0, 2'sd1,
		2'sd1, 2'sd1, 2'sd0, -2'sd1};
	localparam logic signed [1:0] NB_DC [8] = '{2'sd0, 2'sd1, 2'sd1, 2'sd1,
		2'sd0, -2'sd1, -2'sd1, -2'sd1};

	// ceil(2^s / d) for the neighbor counts 1..9
	function automatic logic [31:0] recip(input logic [3:0] d, input int s);
		logic [31:0] one;
		logic [31:0] r;
		one = 32'd1 << s;
		case (d)
			4'd2:    r = (one + 32'd1) / 2;
			4'd3:    r = (one + 32'd2) / 3;
			4'd4:    r = (one + 32'd3) / 4;
			4'd5:    r = (one + 32'd4) / 5;
			4'd6:    r = (one + 32'd5) / 6;
			4'd7:    r = (one + 32'd6) / 7;
			4'd8:    r = (one + 32'd7) / 8;
			4'd9:    r = (one + 32'd8) / 9;
			default: r = one;
		endcase
		return r;
	endfunction

endpackage

### hw/rtl/box_blur_3x3_edge_aware_core.sv
// 3x3 box blur over an RGB raster stream: each output channel is the truncated mean
// of the pixel and those of its eight neighbors that lie inside the frame. Output
// (r,c) appears once input (r+1,c+1) has been taken; after the last pixel, drain
// words (op=1) release the remaining outputs one per word. A pixel word that gives
// no output leaves the block free for the next one. Else the input stalls for nine
// reads of the single-read-port line store, adding the last read, the reciprocal
// multiply and the output register load, held by out_stall. The line store needs no
// clearing after reset. Writing frame_rows or frame_cols starts a new frame.
module box_blur_3x3_edge_aware_core #(
	parameter int MAX_COLS     = bbe_pkg::MAX_COLS_DEF,
	parameter int CHANNEL_BITS = bbe_pkg::CHANNEL_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic                    op,
	input  logic [CHANNEL_BITS-1:0] in_red,
	input  logic [CHANNEL_BITS-1:0] in_green,
	input  logic [CHANNEL_BITS-1:0] in_blue,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [CHANNEL_BITS-1:0] out_red,
	output logic [CHANNEL_BITS-1:0] out_green,
	output logic [CHANNEL_BITS-1:0] out_blue,
	output logic                    frame_last,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic                    cfg_index,
	input  logic [15:0]             cfg_data
);

	localparam int DEPTH = 2 * MAX_COLS + 3;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(MAX_COLS + 1);
	localparam int DW    = $clog2(MAX_COLS + 3) + 1;
	localparam int PW    = 3 * CHANNEL_BITS;
	localparam int SUMW  = CHANNEL_BITS + 4;
	localparam int TW    = AW + 2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_ACC,
		ST_DIV,
		ST_OUT
	} state_t;

	state_t                     state_q;
	logic [15:0]                rows_q;
	logic [11:0]                cols_q;
	logic [AW-1:0]              wp_q, oq_q;
	logic [CW-1:0]              in_col_q, out_col_q;
	logic [15:0]                in_row_q, out_row_q;
	logic [DW-1:0]              pend_q;
	logic [3:0]                 k_q;
	logic                       hit_s1;
	logic [2:0][SUMW-1:0]       sum_q;
	logic [3:0]                 cnt_q;
	logic                       out_valid_q;
	logic [PW-1:0]              out_pix_q;
	logic                       out_last_q;

	logic [15:0]                eff_rows;
	logic [CW-1:0]              eff_cols;
	logic                       in_done, accept, wr_en, emit_pix, emit_drain;
	logic                       cfg_wr, out_free, is_last, acc_en;
	logic signed [1:0]          dr, dc;
	logic                       row_ok, col_ok;
	logic signed [TW-1:0]       off, tsum;
	logic [AW-1:0]              naddr;
	logic [PW-1:0]              rdata;
	logic [2:0][CHANNEL_BITS-1:0] mean;

	assign eff_rows = (rows_q == 16'd0) ? 16'd1 : rows_q;

	always_comb begin
		if (cols_q == 12'd0) begin
			eff_cols = CW'(1);
		end else if (32'(cols_q) > MAX_COLS) begin
			eff_cols = CW'(MAX_COLS);
		end else begin
			eff_cols = CW'(cols_q);
		end
	end

	assign in_done    = in_row_q >= eff_rows;
	// a pending register write holds off the input
	assign in_stall   = (state_q != ST_IDLE) || cfg_valid;
	assign cfg_ready  = state_q == ST_IDLE;
	assign cfg_wr     = cfg_valid && cfg_ready;
	assign accept     = in_valid && !in_stall;
	assign wr_en      = accept && !op && !in_done;
	// new pixel completes the window of the pending output
	assign emit_pix   = wr_en && (32'(pend_q) + 32'd1 >= 32'(eff_cols) + 32'd2);
	assign emit_drain = accept && op && in_done;
	assign out_free   = !out_valid_q || !out_stall;
	assign is_last    = (out_row_q == eff_rows - 16'd1) && (out_col_q == eff_cols - CW'(1));
	assign acc_en     = (state_q == ST_READ && k_q != 4'd0) || state_q == ST_ACC;

	// neighbor k, center last
	always_comb begin
		if (k_q[3]) begin
			dr = 2'sd0;
			dc = 2'sd0;
		end else begin
			dr = bbe_pkg::NB_DR[k_q[2:0]];
			dc = bbe_pkg::NB_DC[k_q[2:0]];
		end
		row_ok = !((dr == -2'sd1 && out_row_q == 16'd0) ||
			(dr == 2'sd1 && out_row_q == eff_rows - 16'd1));
		col_ok = !((dc == -2'sd1 && out_col_q == CW'(0)) ||
			(dc == 2'sd1 && out_col_q == eff_cols - CW'(1)));
		case (dr)
			-2'sd1:  off = -$signed(TW'(eff_cols));
			2'sd1:   off = $signed(TW'(eff_cols));
			default: off = '0;
		endcase
		off  = off + TW'(dc);
		tsum = $signed(TW'(oq_q)) + off;
		if (tsum < 0) begin
			naddr = AW'(tsum + $signed(TW'(DEPTH)));
		end else if (tsum >= $signed(TW'(DEPTH))) begin
			naddr = AW'(tsum - $signed(TW'(DEPTH)));
		end else begin
			naddr = AW'(tsum);
		end
	end

	bbe_line_store #(
		.DEPTH(DEPTH),
		.WIDTH(PW)
	) u_store (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wp_q),
		.wdata({in_red, in_green, in_blue}),
		.raddr(naddr),
		.rdata(rdata)
	);

	bbe_mean_div #(
		.CHANNEL_BITS(CHANNEL_BITS)
	) u_div (
		.clk  (clk),
		.start(state_q == ST_DIV),
		.sum  (sum_q),
		.cnt  (cnt_q),
		.mean (mean)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rows_q      <= bbe_pkg::ROWS_RESET;
			cols_q      <= bbe_pkg::COLS_RESET;
			wp_q        <= '0;
			oq_q        <= '0;
			in_col_q    <= '0;
			in_row_q    <= '0;
			out_col_q   <= '0;
			out_row_q   <= '0;
			pend_q      <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
			out_pix_q   <= '0;
			out_last_q  <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					k_q <= '0;
					if (cfg_wr) begin
						if (bbe_pkg::reg_index_t'(cfg_index) == bbe_pkg::REG_FRAME_ROWS) begin
							rows_q <= cfg_data;
						end else begin
							cols_q <= cfg_data[11:0];
						end
						wp_q      <= '0;
						oq_q      <= '0;
						in_col_q  <= '0;
						in_row_q  <= '0;
						out_col_q <= '0;
						out_row_q <= '0;
						pend_q    <= '0;
					end else if (wr_en) begin
						wp_q   <= (32'(wp_q) == DEPTH - 1) ? '0 : wp_q + AW'(1);
						pend_q <= pend_q + DW'(1);
						if (in_col_q + CW'(1) >= eff_cols) begin
							in_col_q <= '0;
							in_row_q <= in_row_q + 16'd1;
						end else begin
							in_col_q <= in_col_q + CW'(1);
						end
						if (emit_pix) begin
							state_q <= ST_READ;
						end
					end else if (emit_drain) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					k_q <= k_q + 4'd1;
					if (k_q == 4'd8) begin
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_pix_q   <= {mean[0], mean[1], mean[2]};
						out_last_q  <= is_last;
						state_q     <= ST_IDLE;
						if (is_last) begin
							wp_q      <= '0;
							oq_q      <= '0;
							in_col_q  <= '0;
							in_row_q  <= '0;
							out_col_q <= '0;
							out_row_q <= '0;
							pend_q    <= '0;
						end else begin
							oq_q   <= (32'(oq_q) == DEPTH - 1) ? '0 : oq_q + AW'(1);
							pend_q <= pend_q - DW'(1);
							if (out_col_q + CW'(1) >= eff_cols) begin
								out_col_q <= '0;
								out_row_q <= out_row_q + 16'd1;
							end else begin
								out_col_q <= out_col_q + CW'(1);
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// window accumulation, one read behind the address
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			sum_q <= '0;
			cnt_q <= '0;
		end else begin
			if (state_q == ST_READ) begin
				hit_s1 <= row_ok && col_ok;
			end
			if (acc_en && hit_s1) begin
				for (int i = 0; i < 3; i++) begin
					sum_q[i] <= sum_q[i] + SUMW'(rdata[(2 - i) * CHANNEL_BITS +: CHANNEL_BITS]);
				end
				cnt_q <= cnt_q + 4'd1;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign out_red    = out_pix_q[2 * CHANNEL_BITS +: CHANNEL_BITS];
	assign out_green  = out_pix_q[CHANNEL_BITS +: CHANNEL_BITS];
	assign out_blue   = out_pix_q[0 +: CHANNEL_BITS];
	assign frame_last = out_last_q;

endmodule

### hw/rtl/bbe_line_store.sv
module bbe_line_store #(
	parameter int DEPTH = 4099,
	parameter int WIDTH = 24
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### hw/rtl/bbe_mean_div.sv
module bbe_mean_div #(
	parameter int CHANNEL_BITS = 8
) (
	input  logic                          clk,
	input  logic                          start,
	input  logic [2:0][CHANNEL_BITS+3:0]  sum,
	input  logic [3:0]                    cnt,
	output logic [2:0][CHANNEL_BITS-1:0]  mean
);

	localparam int SUMW  = CHANNEL_BITS + 4;
	localparam int SHIFT = SUMW + 4;
	localparam int PRODW = SUMW + SHIFT + 1;

	logic [SHIFT:0]            rcp;
	logic [2:0][PRODW-1:0]     prod_q;

	// reciprocal error stays below 1/16, under the 1/9 gap of a true quotient
	assign rcp = (SHIFT + 1)'(bbe_pkg::recip(cnt, SHIFT));

	always_ff @(posedge clk) begin
		if (start) begin
			for (int i = 0; i < 3; i++) begin
				prod_q[i] <= PRODW'(sum[i]) * PRODW'(rcp);
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mean[i] = prod_q[i][SHIFT +: CHANNEL_BITS];
		end
	end

endmodule

### bench/tb.sv
`timescale 1ns / 100ps

module tb;

	localparam int MAX_COLS    = bbe_pkg::MAX_COLS_DEF;
	localparam int STORE_DEPTH = 2 * MAX_COLS + 3;
	localparam int WATCH_LIMIT = 20000;
	localparam bit OP_PIXEL    = 1'b0;
	localparam bit OP_DRAIN    = 1'b1;

	typedef struct packed {
		logic       op;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} word_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       last;
	} blur_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid, in_stall, op;
	logic [7:0] in_red, in_green, in_blue;
	logic out_valid, out_stall;
	logic [7:0] out_red, out_green, out_blue;
	logic frame_last;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_index = bbe_pkg::REG_FRAME_ROWS;
	logic [15:0] cfg_data = '0;

	word_t pending_words[$];
	blur_t expected_blur[$];
	int errors = 0;
	int src_idle = 0;
	int rcv_stall = 0;
	int quiet_cycles = 0;

	// shadow of the block
	logic [15:0] rows_reg = bbe_pkg::ROWS_RESET;
	logic [11:0] cols_reg = bbe_pkg::COLS_RESET;
	logic [23:0] pix_store [STORE_DEPTH];
	int unsigned in_row = 0, in_col = 0, out_row = 0, out_col = 0;

	always #10 clk = ~clk;

	box_blur_3x3_edge_aware_core i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .op(op),
		.in_red(in_red), .in_green(in_green), .in_blue(in_blue),
		.out_valid(out_valid), .out_stall(out_stall),
		.out_red(out_red), .out_green(out_green), .out_blue(out_blue),
		.frame_last(frame_last),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	function automatic int unsigned geo_rows();
		return (rows_reg == 0) ? 1 : 32'(rows_reg);
	endfunction

	function automatic int unsigned geo_cols();
		if (cols_reg == 0)
			return 1;
		if (cols_reg > MAX_COLS)
			return MAX_COLS;
		return 32'(cols_reg);
	endfunction

	function automatic void restart_frame();
		in_row = 0; in_col = 0; out_row = 0; out_col = 0;
	endfunction

	// mean over the in-frame part of the 3x3 window at the output position
	function automatic blur_t next_blur();
		int unsigned rows, cols, slot, cnt;
		int unsigned sum[3];
		int nr, nc;
		blur_t b;
		rows = geo_rows();
		cols = geo_cols();
		sum = '{0, 0, 0};
		cnt = 0;
		for (int dr = -1; dr <= 1; dr++)
			for (int dc = -1; dc <= 1; dc++) begin
				nr = int'(out_row) + dr;
				nc = int'(out_col) + dc;
				if (nr >= 0 && nr < int'(rows) && nc >= 0 && nc < int'(cols)) begin
					slot = (nr * cols + nc) % STORE_DEPTH;
					sum[0] += pix_store[slot][23:16];
					sum[1] += pix_store[slot][15:8];
					sum[2] += pix_store[slot][7:0];
					cnt++;
				end
			end
		b.red = 8'(sum[0] / cnt);
		b.green = 8'(sum[1] / cnt);
		b.blue = 8'(sum[2] / cnt);
		b.last = (out_row == rows - 1 && out_col == cols - 1);
		out_col++;
		if (out_col >= cols) begin
			out_col = 0;
			out_row++;
		end
		if (b.last)
			restart_frame();
		return b;
	endfunction

	function automatic void blur_word(word_t w);
		int unsigned rows, cols, p, q;
		rows = geo_rows();
		cols = geo_cols();
		if (w.op == OP_DRAIN) begin
			if (in_row >= rows && out_row < rows)
				expected_blur.push_back(next_blur());
			return;
		end
		if (in_row >= rows)
			return;
		p = in_row * cols + in_col;
		q = out_row * cols + out_col;
		pix_store[p % STORE_DEPTH] = {w.red, w.green, w.blue};
		in_col++;
		if (in_col >= cols) begin
			in_col = 0;
			in_row++;
		end
		if (out_row < rows && p >= q + cols + 1)
			expected_blur.push_back(next_blur());
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		word_t w;
		if (!arst_n) begin
			in_valid <= 1'b0;
			op <= OP_PIXEL;
			in_red <= '0;
			in_green <= '0;
			in_blue <= '0;
		end else begin
			if (in_valid && !in_stall)
				blur_word({op, in_red, in_green, in_blue});
			if (!in_valid || !in_stall) begin
				if (pending_words.size() > 0 && $urandom_range(99) >= src_idle) begin
					w = pending_words.pop_front();
					in_valid <= 1'b1;
					op <= w.op;
					in_red <= w.red;
					in_green <= w.green;
					in_blue <= w.blue;
				end else
					in_valid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		blur_t e;
		if (!arst_n)
			out_stall <= 1'b0;
		else begin
			if (out_valid && !out_stall) begin
				if (expected_blur.size() == 0) begin
					errors++;
					$display("%0t: unexpected word %h %h %h last %b", $time,
						out_red, out_green, out_blue, frame_last);
				end else begin
					e = expected_blur.pop_front();
					if (out_red !== e.red || out_green !== e.green ||
							out_blue !== e.blue || frame_last !== e.last) begin
						errors++;
						$display("%0t: expected %h %h %h last %b, got %h %h %h last %b",
							$time, e.red, e.green, e.blue, e.last,
							out_red, out_green, out_blue, frame_last);
					end
				end
			end
			out_stall <= ($urandom_range(99) < rcv_stall);
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCH_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic wait_idle();
		while (pending_words.size() > 0 || in_valid || expected_blur.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(bbe_pkg::reg_index_t idx, logic [15:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == bbe_pkg::REG_FRAME_ROWS)
			rows_reg = val;
		else
			cols_reg = val[11:0];
		restart_frame();
		cfg_valid <= 1'b0;
	endtask

	task automatic push_word(logic o, logic [7:0] r, logic [7:0] g, logic [7:0] b);
		word_t w;
		w.op = o;
		w.red = r;
		w.green = g;
		w.blue = b;
		pending_words.push_back(w);
	endtask

	function automatic logic [7:0] chan_val();
		case ($urandom_range(9))
			0: return 8'h00;
			1: return 8'hff;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	task automatic push_pixels(int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(19) == 0)
				push_word(OP_DRAIN, 8'($urandom_range(255)), 8'($urandom_range(255)),
					8'($urandom_range(255)));
			push_word(OP_PIXEL, chan_val(), chan_val(), chan_val());
		end
	endtask

	task automatic push_drains(int n);
		for (int i = 0; i < n; i++)
			push_word(OP_DRAIN, 8'($urandom_range(255)), 8'($urandom_range(255)),
				8'($urandom_range(255)));
	endtask

	initial begin
		int sent, phase, rows, cols, n;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// zero geometry acts as a single pixel
		write_reg(bbe_pkg::REG_FRAME_ROWS, 16'd0);
		write_reg(bbe_pkg::REG_FRAME_COLS, 16'd0);
		push_word(OP_PIXEL, 8'hff, 8'h00, 8'hff);
		push_word(OP_PIXEL, 8'h12, 8'h34, 8'h56);
		push_drains(2);
		wait_idle();
		// early drain, extremes, extra pixels, empty drain
		write_reg(bbe_pkg::REG_FRAME_ROWS, 16'd2);
		write_reg(bbe_pkg::REG_FRAME_COLS, 16'd3);
		push_word(OP_DRAIN, 8'h00, 8'h00, 8'h00);
		push_word(OP_PIXEL, 8'hff, 8'hff, 8'hff);
		push_word(OP_PIXEL, 8'h00, 8'h00, 8'h00);
		push_word(OP_PIXEL, 8'hff, 8'hff, 8'hff);
		push_word(OP_DRAIN, 8'hff, 8'hff, 8'hff);
		push_word(OP_PIXEL, 8'hff, 8'h00, 8'hff);
		push_word(OP_PIXEL, 8'h00, 8'hff, 8'h00);
		push_word(OP_PIXEL, 8'hfe, 8'h01, 8'h80);
		push_word(OP_PIXEL, 8'h55, 8'haa, 8'h55);
		push_drains(8);
		wait_idle();
		sent = 25;

		phase = 0;
		while (sent < 650) begin
			case (phase % 4)
				0: begin src_idle = 0; rcv_stall = 0; end
				1: begin src_idle = 60; rcv_stall = 0; end
				2: begin src_idle = 0; rcv_stall = 60; end
				default: begin src_idle = 27; rcv_stall = 27; end
			endcase
			case ($urandom_range(7))
				0: begin
					// oversized width clamps, partial frame then restart
					write_reg(bbe_pkg::REG_FRAME_ROWS, 16'd2);
					write_reg(bbe_pkg::REG_FRAME_COLS, 16'hffff);
					push_pixels(40);
					sent += 40;
				end
				1: begin
					write_reg(bbe_pkg::REG_FRAME_ROWS, 16'hffff);
					write_reg(bbe_pkg::REG_FRAME_COLS, 16'd4);
					push_pixels(30);
					sent += 30;
				end
				2: begin
					write_reg(bbe_pkg::REG_FRAME_ROWS, 16'd1);
					write_reg(bbe_pkg::REG_FRAME_COLS, 16'd1);
					push_pixels(1);
					push_drains(2);
					sent += 3;
				end
				default: begin
					rows = $urandom_range(1, 6);
					cols = $urandom_range(1, 9);
					write_reg(bbe_pkg::REG_FRAME_ROWS, 16'(rows));
					write_reg(bbe_pkg::REG_FRAME_COLS, 16'(cols));
					// one or two back to back frames on the same geometry
					for (int f = 0; f < $urandom_range(1, 2); f++) begin
						n = rows * cols;
						push_pixels(n);
						if ($urandom_range(2) == 0)
							push_pixels($urandom_range(1, 3));
						push_drains(n + 1);
						sent += 2 * n;
					end
				end
			endcase
			wait_idle();
			phase++;
		end

		wait_idle();
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
